### rtl/core/tke_pkg.sv
// ----------------------------------------------------------------------------
// tke_pkg
// Shared widths, limits and fixed-point helpers for the tilt estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package tke_pkg;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_CNT_W = 7;

    localparam int MEAS_W = 11;

    localparam logic signed [14:0] GLITCH_ANGLE = -15'sd332;
    localparam logic signed [8:0]  GLITCH_RATE  = -9'sd68;
    localparam logic signed [14:0] MEAS_MAX     = 15'sd1023;
    localparam logic signed [14:0] MEAS_MIN     = -15'sd1024;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // clamp a wide signed value to the 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // arithmetic shift right by 16 or 28, rounding toward zero
    function automatic logic signed [65:0] trunc_shr(input logic signed [65:0] p,
                                                     input logic gain);
        logic signed [65:0] r;
        if (gain) begin
            r = p[65] ? p + 66'sd268435455 : p;
            r = r >>> 28;
        end else begin
            r = p[65] ? p + 66'sd65535 : p;
            r = r >>> 16;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/tilt_kalman_estimator_unit.sv
// ----------------------------------------------------------------------------
// tilt_kalman_estimator_unit
// Tilt angle from raw IMU samples with a two-state angle/bias Kalman filter.
// ----------------------------------------------------------------------------
// Each accepted sample is processed alone: o_ready is low from the transfer
// until the sequencer is back in idle. An item goes through an octant division
// (skipped when its denominator is zero), eleven multiply steps, each through
// ST_MUL_A, ST_MUL_P and ST_MUL_W on the shared 33x33 multiplier, and two gain
// divisions on the shared bit-serial divider. A zero innovation variance skips
// the gain divisions; a glitch sample ends after the octant division with no
// result. A result that still waits in the output register stalls the
// sequencer before idle; once it is taken, the finished result moves there as
// the sequencer returns to idle.
`default_nettype none

module tilt_kalman_estimator_unit
    import tke_pkg::*;
#(
    parameter int OCTANT_UNITS = 128
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire signed [15:0]       i_accel_y,
    input  wire signed [15:0]       i_accel_z,
    input  wire signed [15:0]       i_gyro_x,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic signed [MEAS_W-1:0] o_tilt_estimate,
    output logic signed [MEAS_W-1:0] o_measured_angle,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [4:0]              paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic [2:0] REG_OFFSET = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_SNAP   = 3'd2;
    localparam logic [2:0] REG_DT     = 3'd3;
    localparam logic [2:0] REG_ANOISE = 3'd4;
    localparam logic [2:0] REG_RNOISE = 3'd5;
    localparam logic [2:0] REG_MNOISE = 3'd6;

    localparam logic [3:0] OP_P_ANGLE = 4'd0;
    localparam logic [3:0] OP_P_CROSS = 4'd1;
    localparam logic [3:0] OP_P_AA    = 4'd2;
    localparam logic [3:0] OP_P_OFF   = 4'd3;
    localparam logic [3:0] OP_P_BB    = 4'd4;
    localparam logic [3:0] OP_C_ANGLE = 4'd5;
    localparam logic [3:0] OP_C_BIAS  = 4'd6;
    localparam logic [3:0] OP_C_AA    = 4'd7;
    localparam logic [3:0] OP_C_AB    = 4'd8;
    localparam logic [3:0] OP_C_BA    = 4'd9;
    localparam logic [3:0] OP_C_BB    = 4'd10;

    localparam logic [31:0] UNITS = 32'(OCTANT_UNITS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ANG, ST_MUL_A, ST_MUL_P, ST_MUL_W,
        ST_GAIN, ST_K0, ST_K1, ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic signed [7:0]  r_offset;
    logic [5:0]         r_limit;
    logic [5:0]         r_snap;
    logic [15:0]        r_dt;
    logic [30:0]        r_anoise;
    logic [30:0]        r_rnoise;
    logic [30:0]        r_mnoise;

    // filter state
    logic signed [31:0] r_ae, r_be, r_caa, r_cab, r_cba, r_cbb;

    // working registers
    logic signed [8:0]          r_rate;
    logic                       r_yneg;
    logic                       r_nodiv;
    logic signed [MEAS_W-1:0]   r_meas;
    logic [3:0]                 r_op;
    logic signed [32:0]         r_ma, r_mb;
    logic signed [65:0]         r_prod;
    logic signed [65:0]         r_tmp;
    logic signed [31:0]         r_innov;
    logic signed [33:0]         r_s;
    logic signed [31:0]         r_k0, r_k1;
    logic                       r_qneg;
    logic                       r_ovalid;
    logic signed [MEAS_W-1:0]   r_otilt, r_omeas;

    // ---------------- input stage: rate and octant operands ----------------
    logic               acc;
    logic signed [23:0] gyro_prod;
    logic signed [23:0] gyro_adj;
    logic signed [16:0] ys, xs;
    logic [16:0]        amag;
    logic [31:0]        oct_num, oct_den;
    logic               oct_zero;

    assign acc       = i_valid && o_ready;
    assign gyro_prod = 24'(i_gyro_x) * 24'sd250;
    assign gyro_adj  = gyro_prod[23] ? gyro_prod + 24'sd32767 : gyro_prod;
    assign ys        = -17'(i_accel_z);
    assign xs        = -17'(i_accel_y);
    assign amag      = ys[16] ? 17'(-ys) : 17'(ys);

    always_comb begin
        if (!xs[16]) begin
            oct_num = 32'(UNITS * 32'({15'b0, amag}) * 32'd2);
            oct_den = 32'({15'b0, amag}) + 32'({15'b0, xs});
        end else begin
            oct_num = 32'(UNITS * (32'({15'b0, amag}) * 32'd2 - 32'(xs) * 32'd4));
            oct_den = 32'({15'b0, amag}) - 32'(xs);
        end
    end
    assign oct_zero = (oct_den == 32'd0);

    // ---------------- measured angle after division ----------------
    logic [DIV_NUM_W-1:0] div_quo;
    t_div_stat            div_stat;
    logic [13:0]          ang_mag;
    logic signed [14:0]   ang, meas0, meas_db, meas_sat;
    logic                 glitch;

    assign ang_mag = r_nodiv ? 14'(UNITS * 32'd2) : div_quo[13:0];
    assign ang     = r_yneg ? -15'($signed({1'b0, ang_mag})) : 15'($signed({1'b0, ang_mag}));
    assign meas0   = ang + 15'(r_offset);
    assign glitch  = (meas0 == GLITCH_ANGLE) && (r_rate == GLITCH_RATE);

    always_comb begin
        if (meas0 > 15'sd0 && meas0 <= 15'($signed({1'b0, r_limit}))) begin
            meas_db = 15'($signed({1'b0, r_snap}));
        end else if (meas0 < 15'sd0 && meas0 >= -15'($signed({1'b0, r_limit}))) begin
            meas_db = -15'($signed({1'b0, r_snap}));
        end else begin
            meas_db = meas0;
        end
        if (meas_db > MEAS_MAX) begin
            meas_sat = MEAS_MAX;
        end else if (meas_db < MEAS_MIN) begin
            meas_sat = MEAS_MIN;
        end else begin
            meas_sat = meas_db;
        end
    end

    // ---------------- shared multiplier operands ----------------
    logic signed [32:0] op_a, op_b, dt_op;

    assign dt_op = $signed({17'b0, r_dt});

    always_comb begin
        op_a = 33'(r_k0);
        op_b = 33'(r_innov);
        case (r_op)
            OP_P_ANGLE: begin
                op_a = (33'(r_rate) <<< 16) - 33'(r_be);
                op_b = dt_op;
            end
            OP_P_CROSS: begin
                op_a = 33'(r_cba) + 33'(r_cab);
                op_b = dt_op;
            end
            OP_P_AA: begin
                op_a = $signed({2'b0, r_anoise});
                op_b = dt_op;
            end
            OP_P_OFF: begin
                op_a = 33'(r_cbb);
                op_b = dt_op;
            end
            OP_P_BB: begin
                op_a = $signed({2'b0, r_rnoise});
                op_b = dt_op;
            end
            OP_C_ANGLE: begin
                op_a = 33'(r_k0);
                op_b = 33'(r_innov);
            end
            OP_C_BIAS: begin
                op_a = 33'(r_k1);
                op_b = 33'(r_innov);
            end
            OP_C_AA: begin
                op_a = 33'(r_k0);
                op_b = 33'(r_caa);
            end
            OP_C_AB: begin
                op_a = 33'(r_k0);
                op_b = 33'(r_cab);
            end
            OP_C_BA: begin
                op_a = 33'(r_k1);
                op_b = 33'(r_caa);
            end
            OP_C_BB: begin
                op_a = 33'(r_k1);
                op_b = 33'(r_cab);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    logic signed [65:0] prod_t;
    logic signed [67:0] t68;

    assign prod_t = trunc_shr(r_prod, r_op >= OP_C_ANGLE);
    assign t68    = 68'(prod_t);

    // ---------------- correction terms and gain division ----------------
    logic signed [31:0] innov;
    logic signed [33:0] s_now, s_sel;
    logic [33:0]        s_mag;
    logic [31:0]        caa_mag, cba_mag;
    logic signed [67:0] q_signed;
    logic signed [31:0] gain_q;

    assign innov   = sat32((68'(r_meas) <<< 16) - 68'(r_ae));
    assign s_now   = 34'(r_caa) + $signed({3'b0, r_mnoise});
    assign s_sel   = (r_state == ST_GAIN) ? s_now : r_s;
    assign s_mag   = s_sel[33] ? 34'(-s_sel) : 34'(s_sel);
    assign caa_mag = r_caa[31] ? 32'(-r_caa) : 32'(r_caa);
    assign cba_mag = r_cba[31] ? 32'(-r_cba) : 32'(r_cba);
    assign q_signed = r_qneg ? -$signed({4'b0, div_quo}) : $signed({4'b0, div_quo});
    assign gain_q   = sat32(q_signed);

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;

    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_NUM_W'(oct_num);
        div_den   = DIV_DEN_W'(oct_den);
        case (r_state)
            ST_IDLE: begin
                div_start = acc && !oct_zero;
            end
            ST_GAIN: begin
                div_start = (s_now != 34'sd0);
                div_num   = {4'b0, caa_mag, 28'b0};
                div_den   = s_mag;
            end
            ST_K0: begin
                div_start = div_stat.done;
                div_num   = {4'b0, cba_mag, 28'b0};
                div_den   = s_mag;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    tke_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // ---------------- result ----------------
    logic signed [31:0] ae_adj;
    logic signed [15:0] tilt_full;
    logic signed [MEAS_W-1:0] tilt_sat;

    assign ae_adj    = r_ae[31] ? r_ae + 32'sd65535 : r_ae;
    assign tilt_full = ae_adj[31:16];
    assign tilt_sat  = (tilt_full > 16'sd1023)  ? 11'sd1023 :
                       (tilt_full < -16'sd1024) ? -11'sd1024 : tilt_full[MEAS_W-1:0];

    // ---------------- configuration port ----------------
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        case (cfg_idx)
            REG_OFFSET: prdata = {24'b0, r_offset};
            REG_LIMIT:  prdata = {26'b0, r_limit};
            REG_SNAP:   prdata = {26'b0, r_snap};
            REG_DT:     prdata = {16'b0, r_dt};
            REG_ANOISE: prdata = {1'b0, r_anoise};
            REG_RNOISE: prdata = {1'b0, r_rnoise};
            REG_MNOISE: prdata = {1'b0, r_mnoise};
            default:    prdata = 32'b0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_op     <= OP_P_ANGLE;
            r_offset <= -8'sd38;
            r_limit  <= 6'd5;
            r_snap   <= 6'd11;
            r_dt     <= 16'd590;
            r_anoise <= 31'd268435;
            r_rnoise <= 31'd805306;
            r_mnoise <= 31'd8053064;
            r_ae     <= '0;
            r_be     <= '0;
            r_caa    <= '0;
            r_cab    <= '0;
            r_cba    <= '0;
            r_cbb    <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_OFFSET: r_offset <= pwdata[7:0];
                    REG_LIMIT:  r_limit  <= pwdata[5:0];
                    REG_SNAP:   r_snap   <= pwdata[5:0];
                    REG_DT:     r_dt     <= pwdata[15:0];
                    REG_ANOISE: r_anoise <= pwdata[30:0];
                    REG_RNOISE: r_rnoise <= pwdata[30:0];
                    REG_MNOISE: r_mnoise <= pwdata[30:0];
                    default: ;
                endcase
            end

            if (r_state == ST_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
                r_otilt  <= tilt_sat;
                r_omeas  <= r_meas;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_rate  <= gyro_adj[23:15];
                        r_yneg  <= ys[16];
                        r_nodiv <= oct_zero;
                        r_state <= ST_ANG;
                    end
                end
                ST_ANG: begin
                    if (r_nodiv || div_stat.done) begin
                        if (glitch) begin
                            // drop the sample, filter state untouched
                            r_state <= ST_IDLE;
                        end else begin
                            r_meas  <= meas_sat[MEAS_W-1:0];
                            r_op    <= OP_P_ANGLE;
                            r_state <= ST_MUL_A;
                        end
                    end
                end
                ST_MUL_A: begin
                    r_ma    <= op_a;
                    r_mb    <= op_b;
                    r_state <= ST_MUL_P;
                end
                ST_MUL_P: begin
                    r_prod  <= r_ma * r_mb;
                    r_state <= ST_MUL_W;
                end
                ST_MUL_W: begin
                    case (r_op)
                        OP_P_ANGLE: r_ae  <= sat32(68'(r_ae) + t68);
                        OP_P_CROSS: r_tmp <= prod_t;
                        OP_P_AA:    r_caa <= sat32(68'(r_caa) - 68'(r_tmp) + t68);
                        OP_P_OFF: begin
                            r_cab <= sat32(68'(r_cab) - t68);
                            r_cba <= sat32(68'(r_cba) - t68);
                        end
                        OP_P_BB:    r_cbb <= sat32(68'(r_cbb) + t68);
                        OP_C_ANGLE: r_ae  <= sat32(68'(r_ae) + t68);
                        OP_C_BIAS:  r_be  <= sat32(68'(r_be) + t68);
                        OP_C_AA:    r_caa <= sat32(68'(r_caa) - t68);
                        OP_C_AB:    r_cab <= sat32(68'(r_cab) - t68);
                        OP_C_BA:    r_cba <= sat32(68'(r_cba) - t68);
                        OP_C_BB:    r_cbb <= sat32(68'(r_cbb) - t68);
                        default: ;
                    endcase
                    if (r_op == OP_P_BB) begin
                        r_state <= ST_GAIN;
                    end else if (r_op == OP_C_BB) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_op    <= r_op + 4'd1;
                        r_state <= ST_MUL_A;
                    end
                end
                ST_GAIN: begin
                    r_innov <= innov;
                    r_s     <= s_now;
                    if (s_now == 34'sd0) begin
                        r_k0    <= '0;
                        r_k1    <= '0;
                        r_op    <= OP_C_ANGLE;
                        r_state <= ST_MUL_A;
                    end else begin
                        r_qneg  <= r_caa[31] ^ s_now[33];
                        r_state <= ST_K0;
                    end
                end
                ST_K0: begin
                    if (div_stat.done) begin
                        r_k0    <= gain_q;
                        r_qneg  <= r_cba[31] ^ r_s[33];
                        r_state <= ST_K1;
                    end
                end
                ST_K1: begin
                    if (div_stat.done) begin
                        r_k1    <= gain_q;
                        r_op    <= OP_C_ANGLE;
                        r_state <= ST_MUL_A;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_ovalid;
    assign o_tilt_estimate  = r_otilt;
    assign o_measured_angle = r_omeas;

    a_div_free_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");
    a_op_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op <= OP_C_BB)
        else $error("multiply step out of range");
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !div_stat.busy)
        else $error("divider busy while idle");

endmodule

`default_nettype wire

### rtl/core/tke_div.sv
// ----------------------------------------------------------------------------
// tke_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tke_div
    import tke_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire [DIV_NUM_W-1:0]   i_num,
    input  wire [DIV_DEN_W-1:0]   i_den,
    output t_div_stat             o_stat,
    output logic [DIV_NUM_W-1:0]  o_quo
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DIV_DEN_W:0]   r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W+1:0] diff;

    assign rem_sh = {r_rem[DIV_DEN_W-1:0], r_quo[DIV_NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_cnt != '0) begin
                // shift in the next dividend bit, subtract when it fits
                if (!diff[DIV_DEN_W+1]) begin
                    r_rem <= diff[DIV_DEN_W:0];
                    r_quo <= {r_quo[DIV_NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[DIV_NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_rem <= '0;
                r_quo <= i_num;
                r_den <= i_den;
                r_cnt <= DIV_CNT_W'(DIV_NUM_W);
            end
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && (r_cnt == '0) |=> (r_cnt == DIV_CNT_W'(DIV_NUM_W)))
        else $error("divider did not load on start");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_cnt) == DIV_CNT_W'(1))
        else $error("done without final iteration");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_cnt == '0)
        else $error("done while still busy");

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tilt estimator: a local angle/bias filter model
// predicts every result, driven samples come in bursts, the sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import tke_pkg::*;

    localparam int UNITS       = 128;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 400;

    typedef enum logic [4:0] {
        REG_OFFSET = 5'd0,
        REG_LIMIT  = 5'd4,
        REG_SNAP   = 5'd8,
        REG_DT     = 5'd12,
        REG_QANG   = 5'd16,
        REG_QRATE  = 5'd20,
        REG_RMEAS  = 5'd24
    } t_reg_addr;

    typedef struct packed {
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
    } t_sample;

    typedef struct packed {
        logic signed [10:0] tilt;
        logic signed [10:0] meas;
    } t_tilt_out;

    logic i_clk, i_rst_n, i_valid, i_ready;
    logic signed [15:0] i_accel_y, i_accel_z, i_gyro_x;
    logic o_ready, o_valid, pready;
    logic signed [10:0] o_tilt_estimate, o_measured_angle;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;

    tilt_kalman_estimator_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_accel_y(i_accel_y), .i_accel_z(i_accel_z), .i_gyro_x(i_gyro_x),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_tilt_estimate(o_tilt_estimate), .o_measured_angle(o_measured_angle),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // filter model state and settings
    longint m_offset, m_limit, m_snap, m_dt, m_qang, m_qrate, m_rmeas;
    longint f_angle, f_bias, p00, p01, p10, p11;

    t_sample   sample_q[$];
    t_tilt_out tilt_q[$];
    int  n_mismatch;
    int  idle_cycles;
    bit  timed_out;
    int  stall_mode;
    bit  o_ready_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint clamp32(longint v);
        return clamp(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint scale_dt(longint v);
        return (v * m_dt) / 65536;
    endfunction

    function automatic longint scale_gain(longint k, longint v);
        return (k * v) / (64'sd1 << 28);
    endfunction

    function automatic longint octant_atan(longint y, longint x);
        longint a, ang;
        a = y < 0 ? -y : y;
        if (x >= 0) begin
            ang = (x + a == 0) ? 2 * UNITS : (2 * UNITS * a) / (x + a);
        end else begin
            ang = (UNITS * (2 * a - 4 * x)) / (a - x);
        end
        return y < 0 ? -ang : ang;
    endfunction

    // advance the filter model by one sample; returns 0 for a dropped glitch
    function automatic bit filter_update(t_sample s, output t_tilt_out r);
        longint rate, meas, sv, k0, k1, innov;
        rate = (longint'(s.gx) * 250) / 32768;
        meas = octant_atan(-longint'(s.az), -longint'(s.ay)) + m_offset;
        if (meas == -332 && rate == -68) return 1'b0;
        if (meas > 0 && meas <= m_limit) meas = m_snap;
        else if (meas < 0 && meas >= -m_limit) meas = -m_snap;
        meas = clamp(meas, -1024, 1023);
        f_angle = clamp32(f_angle + scale_dt(rate * 65536 - f_bias));
        p00 = clamp32(p00 - scale_dt(p10 + p01) + scale_dt(m_qang));
        p01 = clamp32(p01 - scale_dt(p11));
        p10 = clamp32(p10 - scale_dt(p11));
        p11 = clamp32(p11 + scale_dt(m_qrate));
        innov = clamp32(meas * 65536 - f_angle);
        sv = p00 + m_rmeas;
        if (sv != 0) begin
            k0 = clamp32((p00 * (64'sd1 << 28)) / sv);
            k1 = clamp32((p10 * (64'sd1 << 28)) / sv);
        end else begin
            k0 = 0;
            k1 = 0;
        end
        f_angle = clamp32(f_angle + scale_gain(k0, innov));
        f_bias  = clamp32(f_bias + scale_gain(k1, innov));
        p00 = clamp32(p00 - scale_gain(k0, p00));
        p01 = clamp32(p01 - scale_gain(k0, p01));
        p10 = clamp32(p10 - scale_gain(k1, p00));
        p11 = clamp32(p11 - scale_gain(k1, p01));
        r.tilt = 11'(clamp(f_angle / 65536, -1024, 1023));
        r.meas = 11'(meas);
        return 1'b1;
    endfunction

    // sender: bursts and gaps
    int burst_left, gap_left;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_seen) begin
                if (gap_left > 0 || sample_q.size() == 0) begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    i_valid   <= 1'b1;
                    i_accel_y <= sample_q[0].ay;
                    i_accel_z <= sample_q[0].az;
                    i_gyro_x  <= sample_q[0].gx;
                    void'(sample_q.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0
                                                                   : $urandom_range(1, 300);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            // receiver stall pattern: long open runs, then choppy phases
            i_ready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, stall_mode) == 0);
        end
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 999) == 0) stall_mode <= $urandom_range(0, 4);
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_tilt_out exp_r, got;
        bit in_xfer, out_xfer;
        in_xfer  = i_rst_n && i_valid && o_ready;
        out_xfer = i_rst_n && o_valid && i_ready;
        o_ready_seen <= in_xfer;
        if (i_rst_n) begin
            idle_cycles <= (in_xfer || out_xfer) ? 0 : idle_cycles + 1;
            if (in_xfer) begin
                t_sample s;
                s = '{ay: i_accel_y, az: i_accel_z, gx: i_gyro_x};
                if (filter_update(s, exp_r)) tilt_q.push_back(exp_r);
            end
            if (out_xfer) begin
                got = '{tilt: o_tilt_estimate, meas: o_measured_angle};
                if (tilt_q.size() == 0) begin
                    n_mismatch = n_mismatch + 1;
                    if (n_mismatch <= 10)
                        $display("unexpected result tilt=%0d meas=%0d", got.tilt, got.meas);
                end else begin
                    exp_r = tilt_q.pop_front();
                    if (got !== exp_r) begin
                        n_mismatch = n_mismatch + 1;
                        if (n_mismatch <= 10)
                            $display("mismatch tilt exp=%0d got=%0d meas exp=%0d got=%0d",
                                     exp_r.tilt, got.tilt, exp_r.meas, got.meas);
                    end
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic reg_write(t_reg_addr a, longint v);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= a; pwdata <= 32'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (a)
            REG_OFFSET: m_offset = longint'(signed'(v[7:0]));
            REG_LIMIT:  m_limit  = v & 64'h3F;
            REG_SNAP:   m_snap   = v & 64'h3F;
            REG_DT:     m_dt     = v & 64'hFFFF;
            REG_QANG:   m_qang   = v & 64'h7FFF_FFFF;
            REG_QRATE:  m_qrate  = v & 64'h7FFF_FFFF;
            default:    m_rmeas  = v & 64'h7FFF_FFFF;
        endcase
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || i_valid || tilt_q.size() != 0) @(posedge i_clk);
        // a dropped glitch may still be in flight
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        case ($urandom_range(0, 3))
            0: s = '{ay: 16'($urandom), az: 16'($urandom), gx: 16'($urandom)};
            1: s = '{ay: 16'($urandom_range(0, 600) - 300),
                     az: 16'($urandom_range(0, 600) - 300),
                     gx: 16'($urandom_range(0, 4000) - 2000)};
            default: s = '{ay: 16'($urandom_range(0, 2000) - 1000),
                           az: 16'(-16384 + $urandom_range(0, 2000)),
                           gx: 16'($urandom_range(0, 600) - 300)};
        endcase
        return s;
    endfunction

    task automatic run_phase(int n);
        repeat (n) sample_q.push_back(rand_sample());
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0;
        i_accel_y = '0; i_accel_z = '0; i_gyro_x = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        burst_left = 1; gap_left = 0; stall_mode = 0; n_mismatch = 0; idle_cycles = 0;
        m_offset = -38; m_limit = 5; m_snap = 11; m_dt = 590;
        m_qang = 268435; m_qrate = 805306; m_rmeas = 8053064;
        f_angle = 0; f_bias = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, octant edges, deadband, glitch
        sample_q.push_back('{ay: 16'sh7FFF, az: 16'sh7FFF, gx: 16'sh7FFF});
        sample_q.push_back('{ay: 16'sh8000, az: 16'sh8000, gx: 16'sh8000});
        sample_q.push_back('{ay: 0, az: 0, gx: 0});
        sample_q.push_back('{ay: 16'sh8000, az: 0, gx: -1});
        sample_q.push_back('{ay: 16'sh7FFF, az: 0, gx: 1});
        sample_q.push_back('{ay: 0, az: 16'sh8000, gx: 16'sh7FFF});
        sample_q.push_back('{ay: 0, az: 16'sh7FFF, gx: 16'sh8000});
        sample_q.push_back('{ay: -1000, az: 1000, gx: 0});
        sample_q.push_back('{ay: 1000, az: -1000, gx: 0});
        sample_q.push_back('{ay: -100, az: -20, gx: 0});  // near offset, hits deadband
        sample_q.push_back('{ay: -100, az: -10, gx: 0});
        sample_q.push_back('{ay: -100, az: 12, gx: 0});
        sample_q.push_back('{ay: 16'sd100, az: 16'sd0, gx: 16'sh8000});
        // glitch: offset -38 + angle -294 = -332, rate -68
        sample_q.push_back('{ay: 19, az: 109, gx: -8913});
        sample_q.push_back('{ay: 19, az: 109, gx: -8913});
        wait_drained();

        // register extremes, including zero dt and zero variance
        reg_write(REG_OFFSET, 127); reg_write(REG_LIMIT, 63); reg_write(REG_SNAP, 63);
        reg_write(REG_DT, 65535); reg_write(REG_QANG, 64'h7FFF_FFFF);
        reg_write(REG_QRATE, 64'h7FFF_FFFF); reg_write(REG_RMEAS, 64'h7FFF_FFFF);
        run_phase(80);
        reg_write(REG_OFFSET, -128); reg_write(REG_LIMIT, 0); reg_write(REG_SNAP, 0);
        reg_write(REG_DT, 0); reg_write(REG_QANG, 0);
        reg_write(REG_QRATE, 0); reg_write(REG_RMEAS, 0);
        run_phase(60);
        reg_write(REG_DT, 1); reg_write(REG_RMEAS, 1);
        run_phase(60);
        reg_write(REG_OFFSET, -38); reg_write(REG_LIMIT, 5); reg_write(REG_SNAP, 11);
        reg_write(REG_DT, 590); reg_write(REG_QANG, 268435);
        reg_write(REG_QRATE, 805306); reg_write(REG_RMEAS, 8053064);
        run_phase(400);
        reg_write(REG_OFFSET, $urandom_range(0, 255)); reg_write(REG_LIMIT, $urandom_range(0, 63));
        reg_write(REG_SNAP, $urandom_range(0, 63)); reg_write(REG_DT, $urandom_range(1, 65535));
        reg_write(REG_QANG, $urandom); reg_write(REG_QRATE, $urandom);
        reg_write(REG_RMEAS, $urandom);
        run_phase(350);

        if (n_mismatch == 0 && tilt_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/tke_pkg.sv
rtl/core/tke_div.sv
rtl/core/tilt_kalman_estimator_unit.sv
dv/tb.sv
